@@ rtl/core/tkd_pkg.sv @@
// ----------------------------------------------------------------------------
// Terminal key decoder package
// Shared key codes, byte constants, widths and the decoder result record.
// ----------------------------------------------------------------------------
package tkd_pkg;

	// Field widths.
	localparam int unsigned DIM_W   = 10;
	localparam int unsigned KIND_W  = 4;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CFG_IDX_W = 1;

	typedef logic [KIND_W-1:0] key_kind_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [DIM_W-1:0]  dim_t;

	// Key codes.
	localparam key_kind_t KEY_NONE  = 4'd0;
	localparam key_kind_t KEY_PLAIN = 4'd1;
	localparam key_kind_t KEY_ESC   = 4'd2;
	localparam key_kind_t KEY_LEFT  = 4'd3;
	localparam key_kind_t KEY_RIGHT = 4'd4;
	localparam key_kind_t KEY_UP    = 4'd5;
	localparam key_kind_t KEY_DOWN  = 4'd6;
	localparam key_kind_t KEY_DEL   = 4'd7;
	localparam key_kind_t KEY_HOME  = 4'd8;
	localparam key_kind_t KEY_END   = 4'd9;
	localparam key_kind_t KEY_PGUP  = 4'd10;
	localparam key_kind_t KEY_PGDN  = 4'd11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

	localparam dim_t ROWS_RESET = 10'd24;
	localparam dim_t COLS_RESET = 10'd80;

	// Byte constants.
	localparam byte_t ESC_BYTE   = 8'h1B;
	localparam byte_t CTRL_MASK  = 8'h1F;
	localparam byte_t QUIT_BYTE  = 8'h71 & CTRL_MASK;
	localparam byte_t LBRACKET   = 8'h5B;
	localparam byte_t SS3_O      = 8'h4F;
	localparam byte_t TILDE      = 8'h7E;

	// Decoder result handed to the cursor logic and the result register.
	typedef struct packed {
		key_kind_t kind;
		byte_t     pbyte;
	} dec_res_t;

endpackage

@@ rtl/core/tkd_decoder.sv @@
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Holds the parse phase and the pending sequence bytes, and turns each
// request into a key code.
// ----------------------------------------------------------------------------
module tkd_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            func,
	input  tkd_pkg::byte_t  in_byte,
	output tkd_pkg::dec_res_t res
);
	import tkd_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ESC   = 2'd1;
	localparam logic [1:0] PH_ESCX  = 2'd2;
	localparam logic [1:0] PH_DIGIT = 2'd3;

	logic [1:0] phase_q, phase_d;
	byte_t      first_q, first_d;
	byte_t      digit_q, digit_d;
	key_kind_t  tilde_kind;
	key_kind_t  bracket_kind;
	key_kind_t  ss3_kind;
	logic       is_digit;

	// Key for ESC [ digit ~.
	always_comb begin
		unique case (digit_q) inside
			8'h31, 8'h37: tilde_kind = KEY_HOME;
			8'h33:        tilde_kind = KEY_DEL;
			8'h34, 8'h38: tilde_kind = KEY_END;
			8'h35:        tilde_kind = KEY_PGUP;
			8'h36:        tilde_kind = KEY_PGDN;
			default:      tilde_kind = KEY_ESC;
		endcase
	end

	// Final letters of ESC [ x and ESC O x.
	always_comb begin
		unique case (in_byte)
			8'h41:   bracket_kind = KEY_UP;
			8'h42:   bracket_kind = KEY_DOWN;
			8'h43:   bracket_kind = KEY_RIGHT;
			8'h44:   bracket_kind = KEY_LEFT;
			8'h48:   bracket_kind = KEY_HOME;
			8'h46:   bracket_kind = KEY_END;
			default: bracket_kind = KEY_ESC;
		endcase
		unique case (in_byte)
			8'h48:   ss3_kind = KEY_HOME;
			8'h46:   ss3_kind = KEY_END;
			default: ss3_kind = KEY_ESC;
		endcase
	end

	assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);

	// Phase transitions and key selection.
	always_comb begin
		phase_d   = phase_q;
		first_d   = first_q;
		digit_d   = digit_q;
		res.kind  = KEY_NONE;
		res.pbyte = '0;
		if (func) begin
			if (phase_q != PH_IDLE) begin
				res.kind = KEY_ESC;
			end
			phase_d = PH_IDLE;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (in_byte == ESC_BYTE) begin
						phase_d = PH_ESC;
					end else begin
						res.kind  = KEY_PLAIN;
						res.pbyte = in_byte;
					end
				end
				PH_ESC: begin
					first_d = in_byte;
					phase_d = PH_ESCX;
				end
				PH_ESCX: begin
					phase_d = PH_IDLE;
					if (first_q == LBRACKET) begin
						if (is_digit) begin
							digit_d = in_byte;
							phase_d = PH_DIGIT;
						end else begin
							res.kind = bracket_kind;
						end
					end else if (first_q == SS3_O) begin
						res.kind = ss3_kind;
					end else begin
						res.kind = KEY_ESC;
					end
				end
				PH_DIGIT: begin
					phase_d  = PH_IDLE;
					res.kind = (in_byte == TILDE) ? tilde_kind : KEY_ESC;
				end
			endcase
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			first_q <= '0;
			digit_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			first_q <= first_d;
			digit_q <= digit_d;
		end
	end

endmodule

@@ rtl/core/tkd_cursor.sv @@
// ----------------------------------------------------------------------------
// Cursor unit
// Holds the cursor position and moves it on the configured grid for each
// decoded key.
// ----------------------------------------------------------------------------
module tkd_cursor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  tkd_pkg::key_kind_t kind,
	input  tkd_pkg::dim_t      rows,
	input  tkd_pkg::dim_t      cols,
	output tkd_pkg::dim_t      col_next,
	output tkd_pkg::dim_t      row_next
);
	import tkd_pkg::*;

	dim_t col_q;
	dim_t row_q;
	dim_t last_row;
	dim_t last_col;

	// A size of zero behaves as one.
	assign last_row = (rows == '0) ? '0 : rows - 10'd1;
	assign last_col = (cols == '0) ? '0 : cols - 10'd1;

	// Next position for the key.
	always_comb begin
		col_next = col_q;
		row_next = row_q;
		case (kind)
			KEY_LEFT: begin
				if (col_q != '0) begin
					col_next = col_q - 10'd1;
				end else if (row_q != '0) begin
					col_next = last_col;
					row_next = row_q - 10'd1;
				end
			end
			KEY_RIGHT: begin
				if (col_q < last_col) begin
					col_next = col_q + 10'd1;
				end else if (row_q < last_row) begin
					col_next = '0;
					row_next = row_q + 10'd1;
				end
			end
			KEY_UP: begin
				if (row_q != '0) begin
					row_next = row_q - 10'd1;
				end
			end
			KEY_DOWN: begin
				if (row_q < last_row) begin
					row_next = row_q + 10'd1;
				end
			end
			KEY_HOME: col_next = '0;
			KEY_END:  col_next = last_col;
			KEY_PGUP: row_next = '0;
			KEY_PGDN: row_next = last_row;
			default: ;
		endcase
	end

	// Position registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (en) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

@@ rtl/core/terminal_key_decoder_cursor_unit.sv @@
// Pipeline: a request is registered in the input register, then decoded into the
// result register once that register is free or being drained; out_valid then rises.
// Throughput: one request per cycle unless out_ready stalls a full result register; the
// decode and the cursor move are a single pass between the input and result registers.
// Reset: arst_n clears the parse phase, the cursor to row 0 column 0, the grid to
// 24 by 80, and both pipeline valid flags. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Terminal key decoder with cursor
// Decodes terminal bytes and timeouts into keys and tracks a cursor on a
// configurable grid.
// ----------------------------------------------------------------------------
module terminal_key_decoder_cursor_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Request channel.
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  func,
	input  logic [7:0]                            in_byte,
	// Result channel.
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [3:0]                            key_kind,
	output logic [7:0]                            plain_byte,
	output logic [9:0]                            cursor_col,
	output logic [9:0]                            cursor_row,
	output logic                                  quit,
	// Configuration channel.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tkd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [9:0]                            cfg_data
);
	import tkd_pkg::*;

	logic      valid_s1;
	logic      func_s1;
	byte_t     byte_s1;
	logic      valid_s2;
	key_kind_t kind_s2;
	byte_t     pbyte_s2;
	dim_t      col_s2;
	dim_t      row_s2;
	logic      quit_s2;
	logic      adv_s1;
	dim_t      rows_q;
	dim_t      cols_q;
	dec_res_t  dec;
	dim_t      col_next;
	dim_t      row_next;

	// Stage 1 moves on when the result register is free or being drained.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	// Grid size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == REG_COLS) begin
				cols_q <= cfg_data;
			end
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			byte_s1 <= in_byte;
		end
	end

	tkd_decoder u_decoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_s1),
		.func    (func_s1),
		.in_byte (byte_s1),
		.res     (dec)
	);

	tkd_cursor u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv_s1),
		.kind     (dec.kind),
		.rows     (rows_q),
		.cols     (cols_q),
		.col_next (col_next),
		.row_next (row_next)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind_s2  <= dec.kind;
			pbyte_s2 <= dec.pbyte;
			col_s2   <= col_next;
			row_s2   <= row_next;
			quit_s2  <= (dec.kind == KEY_PLAIN) && (dec.pbyte == QUIT_BYTE);
		end
	end

	assign out_valid  = valid_s2;
	assign key_kind   = kind_s2;
	assign plain_byte = pbyte_s2;
	assign cursor_col = col_s2;
	assign cursor_row = row_s2;
	assign quit       = quit_s2;

endmodule

@@ rtl/core/tkd_checker.sv @@
// ----------------------------------------------------------------------------
// Terminal key decoder port checker
// Watches the top-level ports for result consistency and a held result
// under backpressure.
// ----------------------------------------------------------------------------
module tkd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [3:0]                    key_kind,
	input logic [7:0]                    plain_byte,
	input logic [9:0]                    cursor_col,
	input logic [9:0]                    cursor_row,
	input logic                          quit
);
	import tkd_pkg::*;

	// A stalled result keeps its key kind and cursor position.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_kind)
			&& $stable(cursor_col) && $stable(cursor_row))
		else $error("result changed while stalled");

	// Only plain keys carry a byte or quit.
	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (key_kind != KEY_PLAIN) |-> (plain_byte == '0) && !quit)
		else $error("byte or quit on a non-plain key");

	// Quit marks exactly the plain Ctrl-Q byte.
	a_quit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quit == ((key_kind == KEY_PLAIN) && (plain_byte == QUIT_BYTE)))
		else $error("quit flag mismatch");

endmodule

bind terminal_key_decoder_cursor_unit tkd_checker u_tkd_checker (.*);
